// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/deq_pkg.sv =====
// Types and constants for the double-ended queue.
// Used by the channel interfaces, deq_ctrl and double_ended_queue; no dependencies.
package deq_pkg;

   localparam int REQ_TYPE_W = 3;
   localparam int DIN_W      = 32;
   localparam int DOUT_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 5;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_PUSH_HEAD = 3'd0,
      REQ_PUSH_TAIL = 3'd1,
      REQ_POP_HEAD  = 3'd2,
      REQ_POP_TAIL  = 3'd3,
      REQ_PEEK_HEAD = 3'd4,
      REQ_PEEK_TAIL = 3'd5
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_POP_EMPTY  = 2'd1,
      STAT_PEEK_EMPTY = 2'd2,
      STAT_PUSH_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   typedef struct packed {
      logic [DOUT_W-1:0] data_out;
      status_type        status;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

endpackage

// ===== src/deq_req_if.sv =====
// Request channel: valid/ready handshake carrying one deque request.
// Depends on deq_pkg.
interface deq_req_if import deq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [DIN_W-1:0]      data_in;

   modport source (output valid, output req_type, output data_in, input ready);
   modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

// ===== src/deq_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one deque result.
// Depends on deq_pkg.
interface deq_rsp_if import deq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DOUT_W-1:0]   data_out;
   logic [STATUS_W-1:0] status;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, output data_out, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input data_out, input status, input occupancy,
                   output ready);
endinterface

// ===== src/deq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/deq_ctrl.sv =====
// Deque control: head/tail indices, count, store access and result register.
// Depends on deq_pkg, deq_req_if, deq_rsp_if and assert_macros.svh.
`include "assert_macros.svh"

module deq_ctrl import deq_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   deq_req_if.sink                  req_if,
   deq_rsp_if.source                rsp_if,
   output logic                     ram_wr_en,
   output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
   output logic [DATA_WIDTH-1:0]    ram_wr_data,
   output logic                     ram_rd_en,
   output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
   input  logic [DATA_WIDTH-1:0]    ram_rd_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             empty;
   logic             full;
   logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
   status_type       status;

   assign req_if.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_FULL);
   assign head_inc = (head_ff == IDX_LAST) ? '0 : head_ff + IDX_W'(1);
   assign head_dec = (head_ff == '0) ? IDX_LAST : head_ff - IDX_W'(1);
   assign tail_inc = (tail_ff == IDX_LAST) ? '0 : tail_ff + IDX_W'(1);
   assign tail_dec = (tail_ff == '0) ? IDX_LAST : tail_ff - IDX_W'(1);

   assign ram_wr_data = DATA_WIDTH'(req_if.data_in);

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      status      = STAT_OK;
      ram_wr_en   = 1'b0;
      ram_wr_addr = tail_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff;
      if (accept) begin
         case (req_code_type'(req_if.req_type))
            REQ_PUSH_HEAD: begin
               if (full) begin
                  status = STAT_PUSH_FULL;
               end else begin
                  head_in     = head_dec;
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = head_dec;
                  count_in    = count_ff + CNT_W'(1);
               end
            end
            REQ_PUSH_TAIL: begin
               if (full) begin
                  status = STAT_PUSH_FULL;
               end else begin
                  tail_in     = tail_inc;
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = tail_ff;
                  count_in    = count_ff + CNT_W'(1);
               end
            end
            REQ_POP_HEAD: begin
               if (empty) begin
                  status = STAT_POP_EMPTY;
               end else begin
                  head_in     = head_inc;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = head_ff;
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            REQ_POP_TAIL: begin
               if (empty) begin
                  status = STAT_POP_EMPTY;
               end else begin
                  tail_in     = tail_dec;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = tail_dec;
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            REQ_PEEK_HEAD: begin
               if (empty) begin
                  status = STAT_PEEK_EMPTY;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = head_ff;
               end
            end
            REQ_PEEK_TAIL: begin
               if (empty) begin
                  status = STAT_PEEK_EMPTY;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = tail_dec;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Reads hold off the request port in S_READ while the word comes back.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in.data_out  = '0;
               rsp_in.status    = status;
               rsp_in.occupancy = OCC_W'(count_in);
               rsp_valid_in     = !ram_rd_en;
               if (ram_rd_en) begin
                  state_in = S_READ;
               end
            end else if (rsp_if.ready) begin
               rsp_valid_in = 1'b0;
            end
         end
         S_READ: begin
            rsp_in.data_out = DOUT_W'(ram_rd_data);
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.data_out  = rsp_ff.data_out;
   assign rsp_if.status    = rsp_ff.status;
   assign rsp_if.occupancy = rsp_ff.occupancy;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_FULL, "count above depth")
   `ASSERT_ALWAYS(a_port_excl, clock, reset, !(ram_wr_en && ram_rd_en), "read and write together")
   `ASSERT_IMPLY(a_read_slot, clock, reset, state_ff == S_READ, !rsp_valid_ff, "result reg busy")
   `ASSERT_NEXT(a_read_done, clock, reset, state_ff == S_READ, rsp_valid_ff && state_ff == S_IDLE, "read result lost")
   `ASSERT_NEXT(a_quick_rsp, clock, reset, accept && !ram_rd_en, rsp_valid_ff, "result not registered")

endmodule

// ===== src/double_ended_queue.sv =====
// Bounded double-ended queue of DEPTH words of DATA_WIDTH bits in a ring store
// (one simple dual-port RAM with registered read). Each request pushes or pops
// at either end, or peeks, and returns one result with the word read, a status
// and the occupancy after the request. Pushes, failed requests and unused codes
// register their result directly; a successful pop or peek waits in S_READ for
// the RAM read, during which the request port is held off. A result left waiting
// in the output register holds off the next request until it is taken. The store
// needs no clearing pass after reset; an entry is only read once it has been written.
// Depends on deq_pkg, deq_req_if, deq_rsp_if, deq_ram and deq_ctrl.
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_if,
   deq_rsp_if.source rsp_if
);

   localparam int IDX_W = $clog2(DEPTH);

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [DATA_WIDTH-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [DATA_WIDTH-1:0] ram_rd_data;

   deq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
